// ----- rtl/bcw_pkg.sv -----
// Shared widths, payload structs and control structs for the barycentric weight pipeline.
// Used by every module of the block; depends on nothing else.
package bcw_pkg;

	// Field widths
	localparam int CW      = 16;              // vertex coordinate width, signed Q12.4
	localparam int CF      = 4;               // coordinate fraction bits
	localparam int PIX_W   = 12;              // pixel row/column width
	localparam int WF      = 16;              // weight fraction bits
	localparam int WW      = WF + 3;          // weight width, signed Q3.WF

	// Datapath widths
	localparam int PXW     = PIX_W + CF;                          // pixel in Q.4 units
	localparam int DW      = ((CW > PXW) ? CW : PXW) + 2;         // coordinate difference
	localparam int PW      = 2 * DW;                              // product
	localparam int SW      = PW + 1;                              // sum of two products
	localparam int NW      = PW + 3;                              // numerators incl. gamma
	localparam int MW      = NW;                                  // magnitudes
	localparam int QW      = WF + 4;                              // 3 integer + WF+1 fraction
	localparam int RW      = MW + 3;                              // divider remainder

	// Stream widths
	localparam int IN_TDATA_W  = ((6 * CW + 2 * PIX_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((3 * WW + 7) / 8) * 8;

	// Per-item control traveling alongside the data
	typedef struct packed {
		logic vld;
		logic zero;    // denominator is zero
	} bcw_ctl_t;

	// Signed numerator as sign of the quotient and magnitude
	typedef struct packed {
		logic          neg;
		logic [MW-1:0] mag;
	} bcw_num_t;

	// One finished result
	typedef struct packed {
		logic                 degenerate;
		logic signed [WW-1:0] weight_c;
		logic signed [WW-1:0] weight_b;
		logic signed [WW-1:0] weight_a;
	} bcw_res_t;

endpackage

// ----- rtl/barycentric_weights.sv -----
// Barycentric weights of one pixel in a 2D triangle: a new request can be taken every
// clock cycle while input ready is high, and its result passes through 28 register stages
// on its way to the output. The divider resolves one quotient bit per pipeline stage (20
// steps, plus an entry and an output stage) after five stages of edge-function arithmetic
// and before one output register. A two-entry output buffer lets requests keep entering
// while one result waits; input ready drops only when both entries are full. A zero
// denominator gives zero weights with tuser set.
module barycentric_weights (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// v1_x, v1_y, v2_x, v2_y, v3_x, v3_y, pixel_x, pixel_y
	input  logic [bcw_pkg::IN_TDATA_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// weight_a, weight_b, weight_c, zero pad
	output logic [bcw_pkg::OUT_TDATA_W-1:0]     m_tdata,
	// degenerate
	output logic                                m_tuser
);
	import bcw_pkg::*;

	logic              ce;
	bcw_ctl_t          edge_ctl, a_ctl, b_ctl, c_ctl;
	bcw_num_t          num_a, num_b, num_c;
	logic [MW-1:0]     den_mag;
	logic signed [WW-1:0] wa, wb, wc;
	bcw_res_t          res_in, res_out;

	assign s_tready = ce;

	// Edge functions
	bcw_edge u_edge (
		.clk     (clk),
		.arst_n  (arst_n),
		.ce      (ce),
		.in_vld  (s_tvalid),
		.v1_x    ($signed(s_tdata[0*CW +: CW])),
		.v1_y    ($signed(s_tdata[1*CW +: CW])),
		.v2_x    ($signed(s_tdata[2*CW +: CW])),
		.v2_y    ($signed(s_tdata[3*CW +: CW])),
		.v3_x    ($signed(s_tdata[4*CW +: CW])),
		.v3_y    ($signed(s_tdata[5*CW +: CW])),
		.pixel_x (s_tdata[6*CW +: PIX_W]),
		.pixel_y (s_tdata[6*CW+PIX_W +: PIX_W]),
		.out_ctl (edge_ctl),
		.num_a   (num_a),
		.num_b   (num_b),
		.num_c   (num_c),
		.den_mag (den_mag)
	);

	// One divider per weight
	bcw_div u_div_a (
		.clk     (clk),
		.arst_n  (arst_n),
		.ce      (ce),
		.in_ctl  (edge_ctl),
		.in_num  (num_a),
		.in_den  (den_mag),
		.out_ctl (a_ctl),
		.weight  (wa)
	);

	bcw_div u_div_b (
		.clk     (clk),
		.arst_n  (arst_n),
		.ce      (ce),
		.in_ctl  (edge_ctl),
		.in_num  (num_b),
		.in_den  (den_mag),
		.out_ctl (b_ctl),
		.weight  (wb)
	);

	bcw_div u_div_c (
		.clk     (clk),
		.arst_n  (arst_n),
		.ce      (ce),
		.in_ctl  (edge_ctl),
		.in_num  (num_c),
		.in_den  (den_mag),
		.out_ctl (c_ctl),
		.weight  (wc)
	);

	// Collect the result
	assign res_in = '{degenerate: a_ctl.zero, weight_c: wc, weight_b: wb, weight_a: wa};

	bcw_obuf u_obuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (a_ctl.vld & ce),
		.in_res  (res_in),
		.ready   (ce),
		.out_vld (m_tvalid),
		.out_rdy (m_tready),
		.out_res (res_out)
	);

	// Pack the stream payload
	assign m_tdata = {{(OUT_TDATA_W-3*WW){1'b0}},
		res_out.weight_c, res_out.weight_b, res_out.weight_a};
	assign m_tuser = res_out.degenerate;

	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(a_ctl.vld == b_ctl.vld) && (a_ctl.vld == c_ctl.vld) &&
		(a_ctl.zero == b_ctl.zero) && (a_ctl.zero == c_ctl.zero))
		else $error("divider lanes out of step");

	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |->
		(res_out.weight_a == '0) && (res_out.weight_b == '0) && (res_out.weight_c == '0))
		else $error("degenerate result with nonzero weights");

endmodule

// ----- rtl/bcw_edge.sv -----
// Edge-function front end: differences, products, sums, gamma numerator, magnitudes.
// Five register stages under a shared enable; depends on bcw_pkg.
module bcw_edge (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          ce,
	input  logic                          in_vld,
	input  logic signed [bcw_pkg::CW-1:0] v1_x,
	input  logic signed [bcw_pkg::CW-1:0] v1_y,
	input  logic signed [bcw_pkg::CW-1:0] v2_x,
	input  logic signed [bcw_pkg::CW-1:0] v2_y,
	input  logic signed [bcw_pkg::CW-1:0] v3_x,
	input  logic signed [bcw_pkg::CW-1:0] v3_y,
	input  logic [bcw_pkg::PIX_W-1:0]     pixel_x,
	input  logic [bcw_pkg::PIX_W-1:0]     pixel_y,
	output bcw_pkg::bcw_ctl_t             out_ctl,
	output bcw_pkg::bcw_num_t             num_a,
	output bcw_pkg::bcw_num_t             num_b,
	output bcw_pkg::bcw_num_t             num_c,
	output logic [bcw_pkg::MW-1:0]        den_mag
);
	import bcw_pkg::*;

	logic signed [DW-1:0] px, py;
	logic                 vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic                 zero_s5;
	logic signed [DW-1:0] a_s1, b_s1, c_s1, d_s1, e_s1, f_s1;
	logic signed [PW-1:0] ad_s2, bc_s2, ae_s2, bf_s2, ce_s2, df_s2;
	logic signed [SW-1:0] den_s3, na_s3, nb_s3;
	logic signed [NW-1:0] den_s4, na_s4, nb_s4, nc_s4;

	// Pixel positions in the same Q.4 units as the vertices
	assign px = $signed({{(DW-PXW){1'b0}}, pixel_x, {CF{1'b0}}});
	assign py = $signed({{(DW-PXW){1'b0}}, pixel_y, {CF{1'b0}}});

	// Gather the control leaving the last stage
	assign out_ctl = '{vld: vld_s5, zero: zero_s5};

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (ce) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// Datapath stages
	always_ff @(posedge clk) begin
		if (ce) begin
			// stage 1: coordinate differences
			a_s1 <= DW'(v2_y) - DW'(v3_y);
			b_s1 <= DW'(v3_x) - DW'(v2_x);
			c_s1 <= DW'(v3_y) - DW'(v1_y);
			d_s1 <= DW'(v1_x) - DW'(v3_x);
			e_s1 <= px - DW'(v3_x);
			f_s1 <= py - DW'(v3_y);
			// stage 2: products
			ad_s2 <= PW'(a_s1) * PW'(d_s1);
			bc_s2 <= PW'(b_s1) * PW'(c_s1);
			ae_s2 <= PW'(a_s1) * PW'(e_s1);
			bf_s2 <= PW'(b_s1) * PW'(f_s1);
			ce_s2 <= PW'(c_s1) * PW'(e_s1);
			df_s2 <= PW'(d_s1) * PW'(f_s1);
			// stage 3: denominator and edge numerators (y1-y3 = -c)
			den_s3 <= SW'(ad_s2) - SW'(bc_s2);
			na_s3  <= SW'(ae_s2) + SW'(bf_s2);
			nb_s3  <= SW'(ce_s2) + SW'(df_s2);
			// stage 4: gamma numerator
			den_s4 <= NW'(den_s3);
			na_s4  <= NW'(na_s3);
			nb_s4  <= NW'(nb_s3);
			nc_s4  <= NW'(den_s3) - NW'(na_s3) - NW'(nb_s3);
			// stage 5: quotient signs and magnitudes
			zero_s5   <= (den_s4 == '0);
			den_mag   <= den_s4[NW-1] ? MW'(-den_s4) : MW'(den_s4);
			num_a.neg <= na_s4[NW-1] ^ den_s4[NW-1];
			num_a.mag <= na_s4[NW-1] ? MW'(-na_s4) : MW'(na_s4);
			num_b.neg <= nb_s4[NW-1] ^ den_s4[NW-1];
			num_b.mag <= nb_s4[NW-1] ? MW'(-nb_s4) : MW'(nb_s4);
			num_c.neg <= nc_s4[NW-1] ^ den_s4[NW-1];
			num_c.mag <= nc_s4[NW-1] ? MW'(-nc_s4) : MW'(nc_s4);
		end
	end

endmodule

// ----- rtl/bcw_div.sv -----
// Pipelined restoring divider for one weight: overflow check, one quotient bit per
// stage, then rounding, sign and saturation to signed Q3.WF. Depends on bcw_pkg.
module bcw_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          ce,
	input  bcw_pkg::bcw_ctl_t             in_ctl,
	input  bcw_pkg::bcw_num_t             in_num,
	input  logic [bcw_pkg::MW-1:0]        in_den,
	output bcw_pkg::bcw_ctl_t             out_ctl,
	output logic signed [bcw_pkg::WW-1:0] weight
);
	import bcw_pkg::*;

	localparam logic [QW-1:0] LIM  = QW'(1) << (WW - 1);
	localparam logic [QW-1:0] SATM = QW'(1) << (QW - 1);
	localparam logic [WW-1:0] WMAX = {1'b0, {(WW-1){1'b1}}};
	localparam logic [WW-1:0] WMIN = {1'b1, {(WW-1){1'b0}}};

	// stage arrays: index 0 is the entry stage, index QW the last quotient step
	bcw_ctl_t      ctl_s [0:QW];
	logic [RW-1:0] rem_s [0:QW];
	logic [RW-1:0] dv_s  [0:QW];
	logic [QW-1:0] quo_s [0:QW];
	logic          sat_s [0:QW];
	logic          neg_s [0:QW];

	logic [QW:0]   rnd;
	logic [QW-1:0] mag;
	logic [QW-1:0] negm;
	logic [WW-1:0] wsel;

	// Entry stage: divisor scaled by eight, flag integer part of eight or more
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else if (ce) begin
			ctl_s[0] <= in_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			rem_s[0] <= RW'(in_num.mag);
			dv_s[0]  <= {in_den, 3'b000};
			quo_s[0] <= '0;
			sat_s[0] <= (RW'(in_num.mag) >= {in_den, 3'b000});
			neg_s[0] <= in_num.neg;
		end
	end

	// Quotient steps, one bit each
	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [RW:0]   t;
		logic [RW+1:0] d;
		logic          ge;

		assign t  = {rem_s[k], 1'b0};
		assign d  = {1'b0, t} - {2'b00, dv_s[k]};
		assign ge = ~d[RW+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k+1] <= '0;
			end else if (ce) begin
				ctl_s[k+1] <= ctl_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				rem_s[k+1] <= ge ? d[RW-1:0] : t[RW-1:0];
				quo_s[k+1] <= {quo_s[k][QW-2:0], ge};
				dv_s[k+1]  <= dv_s[k];
				sat_s[k+1] <= sat_s[k];
				neg_s[k+1] <= neg_s[k];
			end
		end
	end

	// Round half away from zero on the magnitude, then apply sign and clamp
	always_comb begin
		rnd  = {1'b0, quo_s[QW]} + (QW+1)'(1);
		mag  = sat_s[QW] ? SATM : rnd[QW:1];
		negm = QW'(0) - mag;
		if (ctl_s[QW].zero) begin
			wsel = '0;
		end else if (!neg_s[QW]) begin
			wsel = (mag >= LIM) ? WMAX : mag[WW-1:0];
		end else begin
			wsel = (mag > LIM) ? WMIN : negm[WW-1:0];
		end
	end

	// Output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ctl <= '0;
		end else if (ce) begin
			out_ctl <= ctl_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			weight <= $signed(wsel);
		end
	end

endmodule

// ----- rtl/bcw_obuf.sv -----
// Two-entry output buffer: output register plus skid register, so the pipeline keeps
// moving while one result waits. Depends on bcw_pkg.
module bcw_obuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bcw_pkg::bcw_res_t in_res,
	output logic              ready,
	output logic              out_vld,
	input  logic              out_rdy,
	output bcw_pkg::bcw_res_t out_res
);
	import bcw_pkg::*;

	logic     out_v_q, skid_v_q;
	bcw_res_t out_q, skid_q;
	logic     pop;

	// Pipeline may advance unless both entries hold results
	assign ready   = ~(out_v_q & skid_v_q);
	assign pop     = out_v_q & out_rdy;
	assign out_vld = out_v_q;
	assign out_res = out_q;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop || !out_v_q) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= push;
			end else begin
				out_v_q  <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	// Move payloads, oldest at the output
	always_ff @(posedge clk) begin
		if (pop || !out_v_q) begin
			if (skid_v_q) begin
				out_q <= skid_q;
				if (push) begin
					skid_q <= in_res;
				end
			end else begin
				out_q <= in_res;
			end
		end else if (push) begin
			skid_q <= in_res;
		end
	end

	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held while output entry empty");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> ready)
		else $error("result pushed into full output buffer");

	a_skid_fills_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !out_rdy))
		else $error("skid entry filled without a stalled output");

endmodule
